// ===== rtl/core/wa_pkg.sv =====
package wa_pkg;

    // Word precision of the ALU.
    localparam int WORD_BITS = 31;

    // Pipeline: input register, execute stage, one divide stage per quotient bit, output.
    localparam int DIV_FIRST = 2;
    localparam int NUM_STAGES = WORD_BITS + 3;
    localparam int OUT_STAGE = NUM_STAGES - 1;

    localparam int CMD_BITS = 5;
    localparam int ST_BITS = 2;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD     = 5'd0,
        CMD_SUB     = 5'd1,
        CMD_MUL     = 5'd2,
        CMD_NEG     = 5'd3,
        CMD_LT      = 5'd4,
        CMD_GT      = 5'd5,
        CMD_LE      = 5'd6,
        CMD_GE      = 5'd7,
        CMD_SHL     = 5'd8,
        CMD_SHR     = 5'd9,
        CMD_ASHR    = 5'd10,
        CMD_AND     = 5'd11,
        CMD_OR      = 5'd12,
        CMD_XOR     = 5'd13,
        CMD_NOT     = 5'd14,
        CMD_DIV     = 5'd15,
        CMD_MOD     = 5'd16,
        CMD_CONVERT = 5'd17,
        CMD_TOINT   = 5'd18
    } t_cmd;

    localparam logic [ST_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [ST_BITS-1:0] ST_DIVZERO  = 2'd1;
    localparam logic [ST_BITS-1:0] ST_OVERFLOW = 2'd2;

endpackage

// ===== rtl/core/word_alu.sv =====
// word_alu: unsigned integer ALU over 31-bit words, fully pipelined.
// Input channel (i_s_*): each item carries a command in i_s_tuser and two
// operand words in i_s_tdata. Output channel (o_m_*): each item carries the
// word result in o_m_tdata and a status code in o_m_tuser (0 ok, 1 divide
// or modulo by zero, 2 overflow on checked conversion).
// Every command passes through the same 34 register stages, so results are
// offered in the order their items were accepted. A new item may enter
// in every cycle while the pipeline is not full; throughput is one item per
// cycle. The depth is set by the restoring divider, one quotient bit per stage.
// Each stage has its own valid bit and advances when the stage after it is
// empty or advancing, so a stall on o_m_tready holds the finished item at
// the output and lets earlier stages close their bubbles; the input keeps
// accepting until the pipeline is full. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties every stage; the block is ready
// in the first cycle after reset.
module word_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // operand_a [30:0], operand_b [61:31], zeros
    input  logic [4:0]  i_s_tuser,   // cmd [4:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // result [30:0], zero
    output logic [1:0]  o_m_tuser    // status [1:0]
);

    localparam int W = wa_pkg::WORD_BITS;
    localparam int NS = wa_pkg::NUM_STAGES;
    localparam int OS = wa_pkg::OUT_STAGE;

    // Per-stage registers.
    logic                           r_vld [NS];
    logic [wa_pkg::CMD_BITS-1:0]    r_cmd [NS];
    wa_pkg::t_word                  r_res [NS];
    logic [wa_pkg::ST_BITS-1:0]     r_st  [NS];
    logic [W:0]                     r_rem [NS];
    wa_pkg::t_word                  r_quo [NS];
    wa_pkg::t_word                  r_dvs [NS];

    logic                           en [NS];

    // Execute stage results.
    wa_pkg::t_word                  n_res;
    logic [wa_pkg::ST_BITS-1:0]     n_st;
    wa_pkg::t_word                  ex_a;
    wa_pkg::t_word                  ex_b;
    logic [5:0]                     ash_n;

    // Divide step results.
    logic [W:0]                     n_rem [NS];
    wa_pkg::t_word                  n_quo [NS];

    // Final selection.
    wa_pkg::t_word                  n_out;

    // Stage enables: a stage loads when it is empty or its content moves on.
    always_comb begin
        en[OS] = !r_vld[OS] || i_m_tready;
        for (int k = OS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    // Execute stage: every operation but divide and modulo, the multiplier included, and the zero-divisor check.
    always_comb begin
        ex_a  = r_res[0];
        ex_b  = r_dvs[0];
        ash_n = (ex_b > wa_pkg::t_word'(W - 1)) ? 6'(W - 1) : ex_b[5:0];
        n_res = '0;
        n_st  = wa_pkg::ST_OK;
        case (wa_pkg::t_cmd'(r_cmd[0]))
            wa_pkg::CMD_ADD:     n_res = ex_a + ex_b;
            wa_pkg::CMD_SUB:     n_res = ex_a - ex_b;
            wa_pkg::CMD_MUL:     n_res = ex_a * ex_b;
            wa_pkg::CMD_NEG:     n_res = '0 - ex_a;
            wa_pkg::CMD_LT:      n_res = wa_pkg::t_word'(ex_a < ex_b);
            wa_pkg::CMD_GT:      n_res = wa_pkg::t_word'(ex_a > ex_b);
            wa_pkg::CMD_LE:      n_res = wa_pkg::t_word'(ex_a <= ex_b);
            wa_pkg::CMD_GE:      n_res = wa_pkg::t_word'(ex_a >= ex_b);
            wa_pkg::CMD_SHL: begin
                n_res = (ex_b >= wa_pkg::t_word'(W)) ? '0 : (ex_a << ex_b[5:0]);
            end
            wa_pkg::CMD_SHR: begin
                n_res = (ex_b >= wa_pkg::t_word'(W)) ? '0 : (ex_a >> ex_b[5:0]);
            end
            wa_pkg::CMD_ASHR:    n_res = wa_pkg::t_word'($signed(ex_a) >>> ash_n);
            wa_pkg::CMD_AND:     n_res = ex_a & ex_b;
            wa_pkg::CMD_OR:      n_res = ex_a | ex_b;
            wa_pkg::CMD_XOR:     n_res = ex_a ^ ex_b;
            wa_pkg::CMD_NOT:     n_res = ~ex_a;
            wa_pkg::CMD_DIV, wa_pkg::CMD_MOD: begin
                if (ex_b == '0) begin
                    n_st = wa_pkg::ST_DIVZERO;
                end
            end
            wa_pkg::CMD_CONVERT: n_res = ex_a;
            wa_pkg::CMD_TOINT: begin
                if (ex_a[W-1]) begin
                    n_st = wa_pkg::ST_OVERFLOW;
                end else begin
                    n_res = ex_a;
                end
            end
            default:             n_res = '0;
        endcase
    end

    // Restoring divide step per stage: shift in the next dividend bit and
    // subtract the divisor when it fits.
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            logic [W:0] t;
            t = {r_rem[k][W-1:0], r_quo[k][W-1]};
            if (t >= {1'b0, r_dvs[k]}) begin
                n_rem[k] = t - {1'b0, r_dvs[k]};
                n_quo[k] = {r_quo[k][W-2:0], 1'b1};
            end else begin
                n_rem[k] = t;
                n_quo[k] = {r_quo[k][W-2:0], 1'b0};
            end
        end
    end

    // Output selection for divide and modulo.
    always_comb begin
        n_out = r_res[OS-1];
        if (r_st[OS-1] == wa_pkg::ST_DIVZERO) begin
            n_out = '0;
        end else if (wa_pkg::t_cmd'(r_cmd[OS-1]) == wa_pkg::CMD_DIV) begin
            n_out = r_quo[OS-1];
        end else if (wa_pkg::t_cmd'(r_cmd[OS-1]) == wa_pkg::CMD_MOD) begin
            n_out = r_rem[OS-1][W-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        // Input register: operand a rides in the result slot, b in the divisor slot.
        if (en[0]) begin
            r_cmd[0] <= i_s_tuser;
            r_res[0] <= i_s_tdata[W-1:0];
            r_dvs[0] <= i_s_tdata[2*W-1:W];
            r_st[0]  <= wa_pkg::ST_OK;
            r_rem[0] <= '0;
            r_quo[0] <= '0;
        end
        // Execute stage and divider setup.
        if (en[1]) begin
            r_cmd[1] <= r_cmd[0];
            r_res[1] <= n_res;
            r_st[1]  <= n_st;
            r_rem[1] <= '0;
            r_quo[1] <= r_res[0];
            r_dvs[1] <= r_dvs[0];
        end
        // Divide stages.
        for (int k = wa_pkg::DIV_FIRST; k < OS; k++) begin
            if (en[k]) begin
                r_cmd[k] <= r_cmd[k-1];
                r_res[k] <= r_res[k-1];
                r_st[k]  <= r_st[k-1];
                r_rem[k] <= n_rem[k-1];
                r_quo[k] <= n_quo[k-1];
                r_dvs[k] <= r_dvs[k-1];
            end
        end
        // Output register.
        if (en[OS]) begin
            r_cmd[OS] <= r_cmd[OS-1];
            r_res[OS] <= n_out;
            r_st[OS]  <= r_st[OS-1];
            r_rem[OS] <= r_rem[OS-1];
            r_quo[OS] <= r_quo[OS-1];
            r_dvs[OS] <= r_dvs[OS-1];
        end
    end

    assign o_m_tvalid = r_vld[OS];
    assign o_m_tdata  = {1'b0, r_res[OS]};
    assign o_m_tuser  = r_st[OS];

    // An error status always comes with a zero result.
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == wa_pkg::ST_DIVZERO) |-> o_m_tdata == '0)
        else $error("divide by zero with nonzero result");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == wa_pkg::ST_OVERFLOW) |-> o_m_tdata == '0)
        else $error("overflow with nonzero result");

    // An empty output stage never backs up the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output stage");

    // Only the divide and modulo commands may report a zero divisor.
    a_divz_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == wa_pkg::ST_DIVZERO) |->
        (r_cmd[OS] == wa_pkg::CMD_DIV || r_cmd[OS] == wa_pkg::CMD_MOD))
        else $error("zero divisor status on other command");

endmodule

// ===== sim/word_alu_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the ALU, predicts each result and compares it.
module word_alu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // operand_a [30:0], operand_b [61:31], zeros
    input  logic [4:0]  i_s_tuser,   // cmd [4:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // result [30:0], zero
    input  logic [1:0]  i_m_tuser,   // status [1:0]
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        wa_pkg::t_word               word;
        logic [wa_pkg::ST_BITS-1:0]  status;
    } t_alu_out;

    t_alu_out expected_q[$];

    // Computes the result word and status of one command.
    function automatic t_alu_out alu_predict(logic [4:0] op, wa_pkg::t_word a,
                                             wa_pkg::t_word b);
        t_alu_out r;
        logic [2*wa_pkg::WORD_BITS-1:0] prod;
        int unsigned n;
        r.word = '0;
        r.status = wa_pkg::ST_OK;
        case (op)
            wa_pkg::CMD_ADD: r.word = a + b;
            wa_pkg::CMD_SUB: r.word = a - b;
            wa_pkg::CMD_MUL: begin
                prod = a * b;
                r.word = prod[wa_pkg::WORD_BITS-1:0];
            end
            wa_pkg::CMD_NEG: r.word = -a;
            wa_pkg::CMD_LT: r.word = wa_pkg::t_word'(a < b);
            wa_pkg::CMD_GT: r.word = wa_pkg::t_word'(a > b);
            wa_pkg::CMD_LE: r.word = wa_pkg::t_word'(a <= b);
            wa_pkg::CMD_GE: r.word = wa_pkg::t_word'(a >= b);
            wa_pkg::CMD_SHL: r.word = (b >= wa_pkg::WORD_BITS) ? '0 : a << b;
            wa_pkg::CMD_SHR: r.word = (b >= wa_pkg::WORD_BITS) ? '0 : a >> b;
            wa_pkg::CMD_ASHR: begin
                n = (b > wa_pkg::WORD_BITS - 1) ? wa_pkg::WORD_BITS - 1 : b;
                r.word = $signed(a) >>> n;
            end
            wa_pkg::CMD_AND: r.word = a & b;
            wa_pkg::CMD_OR: r.word = a | b;
            wa_pkg::CMD_XOR: r.word = a ^ b;
            wa_pkg::CMD_NOT: r.word = ~a;
            wa_pkg::CMD_DIV, wa_pkg::CMD_MOD: begin
                if (b == 0) begin
                    r.status = wa_pkg::ST_DIVZERO;
                end else begin
                    r.word = (op == wa_pkg::CMD_DIV) ? a / b : a % b;
                end
            end
            wa_pkg::CMD_CONVERT: r.word = a;
            wa_pkg::CMD_TOINT: begin
                if (a[wa_pkg::WORD_BITS-1]) begin
                    r.status = wa_pkg::ST_OVERFLOW;
                end else begin
                    r.word = a;
                end
            end
            default: r.word = '0;
        endcase
        return r;
    endfunction

    assign o_pending = expected_q.size();

    // Predict on each accepted input item, compare on each accepted result.
    always @(posedge i_clk) begin
        t_alu_out want;
        int       bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(alu_predict(i_s_tuser, i_s_tdata[30:0],
                                                 i_s_tdata[61:31]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no item pending: %h", i_m_tdata);
                    bad = 1;
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_tdata !== {1'b0, want.word}) begin
                        $error("result: expected %h, actual %h", want.word, i_m_tdata);
                        bad++;
                    end
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_m_tuser);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY = wa_pkg::NUM_STAGES + 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data;
    logic [4:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;
    logic [1:0]  m_user;
    int          errors;
    int          pending;
    bit          calm;
    bit          hold_off;

    word_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready),
        .i_s_tdata(s_data), .i_s_tuser(s_user),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready),
        .o_m_tdata(m_data), .o_m_tuser(m_user)
    );

    word_alu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready),
        .i_s_tdata(s_data), .i_s_tuser(s_user),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready),
        .i_m_tdata(m_data), .i_m_tuser(m_user),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Random word with a bias toward the edges of the range.
    function automatic wa_pkg::t_word pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return wa_pkg::t_word'($urandom_range(0, 40));
            3: return {1'b1, 30'($urandom)};
            4: return wa_pkg::t_word'(1) << $urandom_range(0, wa_pkg::WORD_BITS - 1);
            default: return wa_pkg::t_word'($urandom);
        endcase
    endfunction

    // Offers one item and holds it until accepted, with random gaps before it.
    task automatic send_item(logic [4:0] op, wa_pkg::t_word a, wa_pkg::t_word b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {2'b00, b, a};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int burst;
        m_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #20ms;
        $display("[word_alu] ERROR");
        $finish;
    end

    initial begin
        wa_pkg::t_word edge_vals[4];
        int            wait_cnt;
        edge_vals = '{'0, '1, {1'b1, 30'd0}, {1'b0, {30{1'b1}}}};
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every command, edge operands, shift clamps, zero divisor.
        for (int op = 0; op <= wa_pkg::CMD_TOINT; op++) begin
            send_item(5'(op), edge_vals[op % 4], edge_vals[(op + 1) % 4]);
        end
        send_item(wa_pkg::CMD_SHL, '1, wa_pkg::t_word'(wa_pkg::WORD_BITS));
        send_item(wa_pkg::CMD_SHR, '1, wa_pkg::t_word'(wa_pkg::WORD_BITS - 1));
        send_item(wa_pkg::CMD_ASHR, {1'b1, 30'd5}, wa_pkg::t_word'(wa_pkg::WORD_BITS));
        send_item(wa_pkg::CMD_DIV, wa_pkg::t_word'(7), '0);
        send_item(wa_pkg::CMD_MOD, wa_pkg::t_word'(7), '0);
        send_item(5'd31, '1, '1);

        // Pause until every result has come back.
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Long receiver hold-off while the sender keeps offering.
        hold_off = 1'b1;
        for (int i = 0; i < 80; i++) begin
            send_item(5'($urandom_range(0, wa_pkg::CMD_TOINT)), pick_word(), pick_word());
        end

        // Random part; the last stretch runs without gaps or stalls.
        for (int i = 0; i < 870; i++) begin
            if (i == 700) calm = 1'b1;
            send_item(($urandom_range(0, 15) == 0) ? 5'($urandom) :
                      5'($urandom_range(0, wa_pkg::CMD_TOINT)), pick_word(), pick_word());
        end
        s_valid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[word_alu] OK");
        end else begin
            $display("[word_alu] ERROR");
        end
        $finish;
    end

endmodule
